// ===== rtl/core/isort_pkg.sv =====
// Shared types and constants for the integer sort engine.
package isort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_COUNT_DEF = 64;

    // one slot of the sorting row: a value and its occupancy flag
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] val;
    } isort_word_t;

endpackage

// ===== rtl/core/integer_sort_engine.sv =====
// Integer sort engine: a row of insertion cells that sorts a set of signed words.
//
// Input stream s_*: one signed 32-bit word per accepted beat, s_tlast closes the set.
// Up to MAX_COUNT words are kept; further words are dropped and flag the run.
// Output stream m_*: the kept words in ascending signed order, m_tlast on the final
// one, m_tuser set on every word of a run that lost words.
// Loading accepts one word per cycle. After the closing word the row settles for the
// time a word needs to ripple down the whole row, then the words leave at one per
// cycle while the receiver keeps taking them.
// s_tready is high only while loading. A stalled receiver holds the output register
// and freezes the row; nothing is lost. The next set may load while the final word
// of the previous run still waits in the output register.
// Reset empties the row, clears the count and the overflow flag, and drops any
// word in the output register.
module integer_sort_engine
    import isort_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic              s_tlast,   // last_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic              m_tlast,   // last_out
    output logic              m_tuser    // [0] overflowed
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_EMIT} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   drain_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic               ovf_reg;
    logic               m_tvalid_reg;
    logic [DATA_W-1:0]  m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;

    logic               in_fire;
    logic               keep;
    logic               take;
    logic               shift;
    isort_word_t        in_word;
    isort_word_t        hold_w [MAX_COUNT];
    isort_word_t        pass_w [MAX_COUNT];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign keep     = in_fire && (count_reg < CNT_W'(MAX_COUNT));
    assign take     = !m_tvalid_reg || m_tready;
    assign shift    = (state_reg == ST_EMIT) && take && (remain_reg != '0);

    assign in_word.ok  = keep;
    assign in_word.val = s_tdata;

    for (genvar i = 0; i < MAX_COUNT; i++)
    begin : g_cell
        isort_word_t cell_in;
        isort_word_t cell_nb;
        if (i == 0)
        begin : g_first
            assign cell_in = in_word;
        end
        else
        begin : g_rest
            assign cell_in = pass_w[i-1];
        end
        if (i == MAX_COUNT - 1)
        begin : g_top
            assign cell_nb = '0;
        end
        else
        begin : g_mid
            assign cell_nb = hold_w[i+1];
        end
        isort_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .in_word   (cell_in),
            .nb_word   (cell_nb),
            .hold_word (hold_w[i]),
            .pass_word (pass_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            drain_reg    <= '0;
            remain_reg   <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (keep)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            drain_reg <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == CNT_W'(MAX_COUNT - 1))
                    begin
                        remain_reg <= count_reg;
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (remain_reg == '0)
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else if (take)
                    begin
                        m_tlast_reg  <= (remain_reg == CNT_W'(1));
                        m_tuser_reg  <= ovf_reg;
                        remain_reg   <= remain_reg - 1'b1;
                        if (remain_reg == CNT_W'(1))
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // output word register, loaded from the bottom cell as the row shifts
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            m_tdata_reg <= hold_w[0].val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // capacity bounds the row: no word ever runs off the top cell
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !pass_w[MAX_COUNT-1].ok)
        else $error("word passed beyond the top cell");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_COUNT))
        else $error("element count exceeds capacity");

    // every emitted word comes from an occupied bottom cell
    a_emit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> hold_w[0].ok)
        else $error("emitting from an empty cell");

    // the settled row is ordered where it is read out
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (shift && (remain_reg > CNT_W'(1))) |->
            (hold_w[1].ok && ($signed(hold_w[0].val) <= $signed(hold_w[1].val))))
        else $error("row out of order at emission");

    a_row_empty_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (shift && (remain_reg == CNT_W'(1))) |=> !hold_w[0].ok)
        else $error("row not empty after final word");
`endif

endmodule

// ===== rtl/core/isort_cell.sv =====
// One cell of the systolic insertion row: keeps the smaller word, hands on the larger.
module isort_cell
    import isort_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,     // emit mode: take the upper neighbor's held word
    input  isort_word_t in_word,   // word arriving from the lower neighbor
    input  isort_word_t nb_word,   // held word of the upper neighbor
    output isort_word_t hold_word,
    output isort_word_t pass_word
);

    logic                     hold_ok_reg, hold_ok_next;
    logic signed [DATA_W-1:0] hold_val_reg, hold_val_next;
    logic                     pass_ok_reg, pass_ok_next;
    logic signed [DATA_W-1:0] pass_val_reg, pass_val_next;
    logic                     in_less;

    assign in_less = $signed(in_word.val) < $signed(hold_val_reg);

    always_comb
    begin
        hold_ok_next  = hold_ok_reg;
        hold_val_next = hold_val_reg;
        pass_ok_next  = 1'b0;
        pass_val_next = pass_val_reg;
        priority if (shift)
        begin
            hold_ok_next  = nb_word.ok;
            hold_val_next = nb_word.val;
        end
        else if (in_word.ok)
        begin
            if (!hold_ok_reg)
            begin
                hold_ok_next  = 1'b1;
                hold_val_next = in_word.val;
            end
            else if (in_less)
            begin
                hold_val_next = in_word.val;
                pass_ok_next  = 1'b1;
                pass_val_next = hold_val_reg;
            end
            else
            begin
                pass_ok_next  = 1'b1;
                pass_val_next = in_word.val;
            end
        end
        else
        begin
            // idle: hold what we have, pass nothing
            hold_ok_next = hold_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ok_reg <= 1'b0;
            pass_ok_reg <= 1'b0;
        end
        else
        begin
            hold_ok_reg <= hold_ok_next;
            pass_ok_reg <= pass_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_val_reg <= hold_val_next;
        pass_val_reg <= pass_val_next;
    end

    assign hold_word.ok  = hold_ok_reg;
    assign hold_word.val = hold_val_reg;
    assign pass_word.ok  = pass_ok_reg;
    assign pass_word.val = pass_val_reg;

endmodule

// ===== sim/integer_sort_engine_test.sv =====
// Self-checking testbench for integer_sort_engine: random sets in, sorted words checked out.
module integer_sort_engine_test;
    import isort_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = MAX_COUNT_DEF;
    localparam int STUCK_MAX  = 4000;
    localparam int ITEM_GOAL  = 210;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              dropped;
    } sorted_word_t;

    // Tracks the set being loaded and the sorted words still owed by the block.
    class sort_scoreboard;
        logic signed [DATA_W-1:0] held[CAPACITY];
        int           held_count;
        bit           lost_any;
        sorted_word_t owed[$];
        int           errors;
        int           checked;

        function new();
            held_count = 0;
            lost_any   = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void note_word(logic [DATA_W-1:0] v, logic l);
            logic signed [DATA_W-1:0] key;
            sorted_word_t             w;
            int                       i;
            int                       k;
            if (held_count < CAPACITY)
            begin
                held[held_count] = v;
                held_count++;
            end
            else
            begin
                lost_any = 1;
            end
            if (!l)
                return;
            for (i = 1; i < held_count; i++)
            begin
                key = held[i];
                k   = i;
                while (k > 0 && held[k-1] > key)
                begin
                    held[k] = held[k-1];
                    k--;
                end
                held[k] = key;
            end
            for (i = 0; i < held_count; i++)
            begin
                w.value   = held[i];
                w.last    = (i == held_count - 1);
                w.dropped = lost_any;
                owed.push_back(w);
            end
            held_count = 0;
            lost_any   = 0;
        endfunction

        function void check_word(logic [DATA_W-1:0] v, logic l, logic u);
            sorted_word_t w;
            checked++;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual value %h last %b ovf %b",
                         $time, v, l, u);
                return;
            end
            w = owed.pop_front();
            if (v !== w.value)
            begin
                errors++;
                $display("%0t: value mismatch: expected %h, actual %h", $time, w.value, v);
            end
            if (l !== w.last)
            begin
                errors++;
                $display("%0t: tlast mismatch: expected %b, actual %b", $time, w.last, l);
            end
            if (u !== w.dropped)
            begin
                errors++;
                $display("%0t: overflow flag mismatch: expected %b, actual %b",
                         $time, w.dropped, u);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    sort_scoreboard sb;
    int  stuck_cycles = 0;
    int  words_sent;
    int  sets_sent;
    int  overflow_sets;
    int  stall_left = 0;
    bit  tx_steady;
    bit  rx_steady = 1'b0;

    integer_sort_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(bit narrow);
        int r;
        r = $urandom_range(0, 9);
        if (narrow || r == 2)
            return DATA_W'($signed($urandom_range(0, 8)) - 4);
        if (r == 0)
            return MOST_NEG;
        if (r == 1)
            return MOST_POS;
        return $urandom;
    endfunction

    task automatic send_set(input logic [DATA_W-1:0] vals[$]);
        int gap;
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < vals.size(); i++)
        begin
            gap = tx_steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= vals[i];
            s_tlast  <= (i == vals.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
            sb.note_word(vals[i], i == vals.size() - 1);
            words_sent++;
        end
        sets_sent++;
        if (vals.size() > CAPACITY)
            overflow_sets++;
    endtask

    task automatic send_random_set(input int len);
        logic [DATA_W-1:0] vals[$];
        bit                narrow;
        narrow = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            vals.push_back(pick_value(narrow));
        send_set(vals);
    endtask

    // sink side: random backpressure, result checking and the stall counter
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_word(m_tdata, m_tlast, m_tuser);
            if (m_tlast)
                rx_steady = ($urandom_range(0, 2) == 0);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (stuck_cycles < STUCK_MAX)
            @(posedge clk);
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, STUCK_MAX, sb.owed.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin : main
        sb            = new();
        words_sent    = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        tx_steady     = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets: single word, extremes, duplicates, reversed order
        send_set('{32'h0000_0000});
        send_set('{MOST_POS, MOST_NEG});
        send_set('{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, MOST_NEG, MOST_POS,
                   32'h8000_0001, 32'h7FFF_FFFE, MOST_NEG});
        send_set('{32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005});
        send_set('{32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000,
                   32'hFFFF_FFFF});
        send_set('{32'h5555_5555, 32'hAAAA_AAAA});

        // exactly full, overflow on the last word only, overflow with last dropped
        send_random_set(CAPACITY);
        send_random_set(CAPACITY + 1);
        send_random_set(CAPACITY + 3);
        while (words_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0:       send_random_set($urandom_range(CAPACITY - 4, CAPACITY + 4));
                1, 2:    send_random_set($urandom_range(13, 40));
                default: send_random_set($urandom_range(1, 12));
            endcase
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.owed.size() > 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 16) @(posedge clk);

        $display("covered %0d sets, %0d words loaded (%0d sets past capacity)",
                 sets_sent, words_sent, overflow_sets);
        $display("checked %0d sorted words, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
